>>> rtl/core/decimal_fixed_point_alu_top_macros.svh
// ----------------------------------------------------------------------------
// decimal fixed-point alu assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef DECIMAL_FIXED_POINT_ALU_TOP_MACROS_SVH
`define DECIMAL_FIXED_POINT_ALU_TOP_MACROS_SVH
`ifndef SYNTH
`define DFPA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define DFPA_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define DFPA_ASSERT(label, clk, rst, prop)
`define DFPA_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

>>> rtl/core/dfpa_pkg.sv
// ----------------------------------------------------------------------------
// dfpa_pkg
// shared types and constants of the decimal fixed-point alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfpa_pkg;

   localparam int DefDecimalDigits = 6;
   localparam int DataWidth        = 64;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_MUL   = 3'd1,
      OP_DIV   = 3'd2,
      OP_MOD   = 3'd3,
      OP_CLAMP = 3'd4,
      OP_CMP   = 3'd5
   } dfpa_op_type;

   typedef struct packed {
      dfpa_op_type           op;
      logic                  neg;
      logic                  neg_a;
      logic                  lt;
      logic                  eq;
      logic                  dz;
      logic                  pre_ovf;
      logic                  big;
      logic [DataWidth-1:0]  pre_res;
   } dfpa_side_type;

   function automatic logic [DataWidth-1:0] pow10(input int n);
      logic [DataWidth-1:0] s;
      s = 64'd1;
      for (int i = 0; i < n; i++) begin
         s = s * 64'd10;
      end
      return s;
   endfunction

endpackage

>>> rtl/core/decimal_fixed_point_alu_top.sv
// ----------------------------------------------------------------------------
// decimal_fixed_point_alu_top
// signed 64-bit decimal fixed-point alu: add, multiply, divide, modulo one,
// clamp and compare, with saturation
// ----------------------------------------------------------------------------
// channel  dir  handshake           payload
// req      in   req_tvalid/tready   tdata a,b,c; tuser op
// rsp      out  rsp_tvalid/tready   tdata result and four flags
//
// one beat per cycle while the result side is not stalled
// the 64-stage restoring divider is shared by mul, div and mod
// reset clears every valid bit; no clearing pass
// a stalled result freezes the whole pipeline; req_tready follows rsp_tready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_fixed_point_alu_top_macros.svh"

module decimal_fixed_point_alu_top
   import dfpa_pkg::*;
#(
   parameter int DECIMAL_DIGITS = DefDecimalDigits
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [191:0]  req_tdata,   // operand_a, operand_b, operand_c
   input  logic [2:0]    req_tuser,   // req_type
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [71:0]   rsp_tdata    // result_value, less_than, equal_flag,
                                      // divide_by_zero, overflow_flag, zero pad
);

   localparam logic [DataWidth-1:0] Scale   = pow10(DECIMAL_DIGITS);
   localparam logic [DataWidth-1:0] QuotMax = 64'hFFFF_FFFF_FFFF_FFFF / Scale;
   localparam logic [DataWidth-1:0] SignBit = 64'h8000_0000_0000_0000;
   localparam logic [DataWidth-1:0] PosMax  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int                   Steps   = DataWidth;

   function automatic logic [DataWidth:0] pack(input logic neg,
                                               input logic [DataWidth-1:0] mag,
                                               input logic big);
      logic [DataWidth:0] r;
      if (neg) begin
         if (big || mag > SignBit) r = {1'b1, SignBit};
         else                      r = {1'b0, 64'd0 - mag};
      end else begin
         if (big || mag > PosMax)  r = {1'b1, PosMax};
         else                      r = {1'b0, mag};
      end
      return r;
   endfunction

   // high half only seeds the remainder when it stays below the scale
   function automatic logic [DataWidth-1:0] s3_side_in_rem(input logic [DataWidth-1:0] hi);
      return (hi >= Scale) ? 64'd0 : hi;
   endfunction

   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage 0: input register
   logic                  s0_valid_ff;
   dfpa_op_type           s0_op_ff;
   logic [DataWidth-1:0]  s0_a_ff, s0_b_ff, s0_c_ff;

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else if (en) s0_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_op_ff <= dfpa_op_type'(req_tuser);
         s0_a_ff  <= req_tdata[63:0];
         s0_b_ff  <= req_tdata[127:64];
         s0_c_ff  <= req_tdata[191:128];
      end
   end

   // stage 1: magnitudes, flags, simple ops
   logic                  s1_valid_ff;
   dfpa_side_type         s1_side_ff, s1_side_in;
   logic [DataWidth-1:0]  s1_ma_ff, s1_ma_in, s1_mb_ff, s1_mb_in;
   logic [DataWidth-1:0]  sum;
   logic                  na, nb, c_lt_a, a_lt_b;

   always_comb begin
      na     = s0_a_ff[DataWidth-1];
      nb     = s0_b_ff[DataWidth-1];
      a_lt_b = $signed(s0_a_ff) < $signed(s0_b_ff);
      c_lt_a = $signed(s0_c_ff) < $signed(s0_a_ff);
      sum    = s0_a_ff + s0_b_ff;
      s1_ma_in = na ? 64'd0 - s0_a_ff : s0_a_ff;
      s1_mb_in = nb ? 64'd0 - s0_b_ff : s0_b_ff;
      s1_side_in         = '0;
      s1_side_in.op      = s0_op_ff;
      s1_side_in.neg     = na ^ nb;
      s1_side_in.neg_a   = na;
      s1_side_in.lt      = a_lt_b;
      s1_side_in.eq      = s0_a_ff == s0_b_ff;
      s1_side_in.dz      = (s0_op_ff == OP_DIV) && (s0_b_ff == 64'd0);
      case (s0_op_ff)
         OP_ADD: begin
            if (na == nb && sum[DataWidth-1] != na) begin
               s1_side_in.pre_ovf = 1'b1;
               s1_side_in.pre_res = na ? SignBit : PosMax;
            end else begin
               s1_side_in.pre_res = sum;
            end
         end
         OP_CLAMP: begin
            if (c_lt_a)      s1_side_in.pre_res = s0_c_ff;
            else if (a_lt_b) s1_side_in.pre_res = s0_b_ff;
            else             s1_side_in.pre_res = s0_a_ff;
         end
         default: s1_side_in.pre_res = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (en) s1_valid_ff <= s0_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff <= s1_side_in;
         s1_ma_ff   <= s1_ma_in;
         s1_mb_ff   <= s1_mb_in;
      end
   end

   // stage 2: 32x32 partial products
   logic                  s2_valid_ff;
   dfpa_side_type         s2_side_ff;
   logic [DataWidth-1:0]  s2_ma_ff, s2_mb_ff;
   logic [DataWidth-1:0]  s2_ll_ff, s2_lh_ff, s2_hl_ff, s2_hh_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (en) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_side_ff <= s1_side_ff;
         s2_ma_ff   <= s1_ma_ff;
         s2_mb_ff   <= s1_mb_ff;
         s2_ll_ff   <= {32'd0, s1_ma_ff[31:0]}  * {32'd0, s1_mb_ff[31:0]};
         s2_lh_ff   <= {32'd0, s1_ma_ff[31:0]}  * {32'd0, s1_mb_ff[63:32]};
         s2_hl_ff   <= {32'd0, s1_ma_ff[63:32]} * {32'd0, s1_mb_ff[31:0]};
         s2_hh_ff   <= {32'd0, s1_ma_ff[63:32]} * {32'd0, s1_mb_ff[63:32]};
      end
   end

   // stage 3: full product
   logic                  s3_valid_ff;
   dfpa_side_type         s3_side_ff;
   logic [DataWidth-1:0]  s3_ma_ff, s3_mb_ff;
   logic [127:0]          s3_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (en) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_side_ff <= s2_side_ff;
         s3_ma_ff   <= s2_ma_ff;
         s3_mb_ff   <= s2_mb_ff;
         s3_prod_ff <= {64'd0, s2_ll_ff} + {32'd0, s2_lh_ff, 32'd0}
                     + {32'd0, s2_hl_ff, 32'd0} + {s2_hh_ff, 64'd0};
      end
   end

   // stage 4: divider setup
   logic                  s4_valid_ff;
   dfpa_side_type         s4_side_ff, s4_side_in;
   logic [DataWidth-1:0]  s4_rem_ff, s4_rem_in;
   logic [DataWidth-1:0]  s4_work_ff, s4_work_in;
   logic [DataWidth-1:0]  s4_div_ff, s4_div_in;

   always_comb begin
      s4_side_in = s3_side_ff;
      s4_rem_in  = 64'd0;
      s4_work_in = s3_ma_ff;
      s4_div_in  = Scale;
      case (s3_side_ff.op)
         OP_MUL: begin
            s4_side_in.big = s3_prod_ff[127:64] >= Scale;
            s4_rem_in      = s3_side_in_rem(s3_prod_ff[127:64]);
            s4_work_in     = s3_prod_ff[63:0];
         end
         OP_DIV:  s4_div_in = s3_mb_ff;
         default: s4_div_in = Scale;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (en) s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_side_ff <= s4_side_in;
         s4_rem_ff  <= s4_rem_in;
         s4_work_ff <= s4_work_in;
         s4_div_ff  <= s4_div_in;
      end
   end

   // divider stages
   logic                  dv_valid [0:Steps];
   dfpa_side_type         dv_side  [0:Steps];
   logic [DataWidth-1:0]  dv_rem   [0:Steps];
   logic [DataWidth-1:0]  dv_work  [0:Steps];
   logic [DataWidth-1:0]  dv_div   [0:Steps];

   assign dv_valid[0] = s4_valid_ff;
   assign dv_side[0]  = s4_side_ff;
   assign dv_rem[0]   = s4_rem_ff;
   assign dv_work[0]  = s4_work_ff;
   assign dv_div[0]   = s4_div_ff;

   for (genvar g = 0; g < Steps; g++) begin : g_div
      dfpa_div_step u_step (
         .clock       (clock),
         .reset       (reset),
         .enable      (en),
         .in_valid    (dv_valid[g]),
         .in_side     (dv_side[g]),
         .in_rem      (dv_rem[g]),
         .in_work     (dv_work[g]),
         .in_divisor  (dv_div[g]),
         .out_valid   (dv_valid[g+1]),
         .out_side    (dv_side[g+1]),
         .out_rem     (dv_rem[g+1]),
         .out_work    (dv_work[g+1]),
         .out_divisor (dv_div[g+1])
      );
   end

   // post stage 1: quotient times scale, partial products
   logic                  p1_valid_ff;
   dfpa_side_type         p1_side_ff;
   logic [DataWidth-1:0]  p1_q_ff, p1_r_ff;
   logic                  p1_qbig_ff;
   logic [DataWidth-1:0]  p1_ll_ff, p1_lh_ff, p1_hl_ff;

   always_ff @(posedge clock) begin
      if (reset) p1_valid_ff <= 1'b0;
      else if (en) p1_valid_ff <= dv_valid[Steps];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_side_ff <= dv_side[Steps];
         p1_q_ff    <= dv_work[Steps];
         p1_r_ff    <= dv_rem[Steps];
         p1_qbig_ff <= dv_work[Steps] > QuotMax;
         p1_ll_ff   <= {32'd0, dv_work[Steps][31:0]}  * {32'd0, Scale[31:0]};
         p1_lh_ff   <= {32'd0, dv_work[Steps][31:0]}  * {32'd0, Scale[63:32]};
         p1_hl_ff   <= {32'd0, dv_work[Steps][63:32]} * {32'd0, Scale[31:0]};
      end
   end

   // post stage 2: low product sum
   logic                  p2_valid_ff;
   dfpa_side_type         p2_side_ff;
   logic [DataWidth-1:0]  p2_q_ff, p2_r_ff, p2_qs_ff;
   logic                  p2_qbig_ff;

   always_ff @(posedge clock) begin
      if (reset) p2_valid_ff <= 1'b0;
      else if (en) p2_valid_ff <= p1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_side_ff <= p1_side_ff;
         p2_q_ff    <= p1_q_ff;
         p2_r_ff    <= p1_r_ff;
         p2_qbig_ff <= p1_qbig_ff;
         p2_qs_ff   <= p1_ll_ff + {p1_lh_ff[31:0] + p1_hl_ff[31:0], 32'd0};
      end
   end

   // output register
   logic                  out_valid_ff;
   dfpa_op_type           out_op_ff;
   logic [DataWidth-1:0]  out_res_ff, out_res_in;
   logic                  out_lt_ff, out_eq_ff, out_dz_ff, out_ovf_ff, out_ovf_in;
   logic [DataWidth:0]    packed_v;

   always_comb begin
      packed_v   = '0;
      out_res_in = p2_side_ff.pre_res;
      out_ovf_in = p2_side_ff.pre_ovf;
      case (p2_side_ff.op)
         OP_MUL: begin
            packed_v   = pack(p2_side_ff.neg, p2_q_ff, p2_side_ff.big);
            out_res_in = packed_v[DataWidth-1:0];
            out_ovf_in = packed_v[DataWidth];
         end
         OP_DIV: begin
            packed_v = pack(p2_side_ff.neg, p2_qbig_ff ? 64'd0 : p2_qs_ff, p2_qbig_ff);
            if (p2_side_ff.dz) begin
               out_res_in = 64'd0;
               out_ovf_in = 1'b0;
            end else begin
               out_res_in = packed_v[DataWidth-1:0];
               out_ovf_in = packed_v[DataWidth];
            end
         end
         OP_MOD: begin
            out_ovf_in = 1'b0;
            if (p2_side_ff.neg_a && p2_r_ff != 64'd0) out_res_in = Scale - p2_r_ff;
            else                                      out_res_in = p2_r_ff;
         end
         default: out_res_in = p2_side_ff.pre_res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (en) out_valid_ff <= p2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_op_ff  <= p2_side_ff.op;
         out_res_ff <= out_res_in;
         out_lt_ff  <= p2_side_ff.lt;
         out_eq_ff  <= p2_side_ff.eq;
         out_dz_ff  <= p2_side_ff.dz;
         out_ovf_ff <= out_ovf_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ovf_ff, out_dz_ff, out_eq_ff, out_lt_ff, out_res_ff};

   `DFPA_ASSERT(a_dz_gives_zero, clock, reset, rsp_tvalid && out_dz_ff |-> out_res_ff == 64'd0 && !out_ovf_ff)
   `DFPA_ASSERT(a_dz_only_div, clock, reset, rsp_tvalid && out_dz_ff |-> out_op_ff == OP_DIV)
   `DFPA_ASSERT(a_mod_in_range, clock, reset, rsp_tvalid && out_op_ff == OP_MOD |-> out_res_ff < Scale && !out_ovf_ff)
   `DFPA_ASSERT_NEVER(a_cmp_nonzero, clock, reset, rsp_tvalid && out_op_ff == OP_CMP && out_res_ff != 64'd0)

endmodule

>>> rtl/core/dfpa_div_step.sv
// ----------------------------------------------------------------------------
// dfpa_div_step
// one registered restoring-division step: one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfpa_div_step
   import dfpa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  dfpa_side_type         in_side,
   input  logic [DataWidth-1:0]  in_rem,
   input  logic [DataWidth-1:0]  in_work,
   input  logic [DataWidth-1:0]  in_divisor,
   output logic                  out_valid,
   output dfpa_side_type         out_side,
   output logic [DataWidth-1:0]  out_rem,
   output logic [DataWidth-1:0]  out_work,
   output logic [DataWidth-1:0]  out_divisor
);

   logic                  valid_ff;
   dfpa_side_type         side_ff;
   logic [DataWidth-1:0]  rem_ff, rem_in;
   logic [DataWidth-1:0]  work_ff, work_in;
   logic [DataWidth-1:0]  divisor_ff;
   logic [DataWidth:0]    trial;
   logic [DataWidth:0]    diff;
   logic                  ge;

   always_comb begin
      trial   = {in_rem, in_work[DataWidth-1]};
      diff    = trial - {1'b0, in_divisor};
      ge      = ~diff[DataWidth];
      rem_in  = ge ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
      work_in = {in_work[DataWidth-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff    <= in_side;
         rem_ff     <= rem_in;
         work_ff    <= work_in;
         divisor_ff <= in_divisor;
      end
   end

   assign out_valid   = valid_ff;
   assign out_side    = side_ff;
   assign out_rem     = rem_ff;
   assign out_work    = work_ff;
   assign out_divisor = divisor_ff;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench for decimal_fixed_point_alu_top
// drives add, multiply, divide, modulo one, clamp, compare and the unused
// codes through the request stream with bursty gaps and a stalling result
// side, predicts every result in scaled arithmetic with 128-bit intermediates and checks each
// result beat field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
   import dfpa_pkg::*;
();

   localparam logic [63:0] ScaleFactor = 64'd1000000;
   localparam logic [63:0] PosMax = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NegMin = 64'h8000_0000_0000_0000;
   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 200;
   localparam logic [2:0] CodeSpareLo = 3'd6;
   localparam logic [2:0] CodeSpareHi = 3'd7;

   // packed from the top bit down: flags above the value, as on rsp_tdata
   typedef struct packed {
      logic        ovf;
      logic        dz;
      logic        eq;
      logic        lt;
      logic [63:0] value;
   } alu_result_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [191:0]  req_tdata;   // operand_a, operand_b, operand_c
   logic [2:0]    req_tuser;   // req_type
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [71:0]   rsp_tdata;   // result_value, less_than, equal_flag,
                               // divide_by_zero, overflow_flag, zero pad

   alu_result_type pending_results[$];
   int            mismatch_count;
   int            cycle_count;
   int            hold_off_cycles;
   bit            stall_enable;

   decimal_fixed_point_alu_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] abs64(logic [63:0] x);
      return x[63] ? (64'd0 - x) : x;
   endfunction

   function automatic logic [63:0] saturate(input logic neg, input logic [127:0] mag,
                                            output logic ovf);
      ovf = 1'b0;
      if (neg) begin
         if (mag > {64'd0, NegMin}) begin
            ovf = 1'b1;
            return NegMin;
         end
         return 64'd0 - mag[63:0];
      end
      if (mag > {64'd0, PosMax}) begin
         ovf = 1'b1;
         return PosMax;
      end
      return mag[63:0];
   endfunction

   function automatic alu_result_type compute_alu(logic [2:0] code, logic [63:0] a,
                                                  logic [63:0] b, logic [63:0] c);
      alu_result_type r;
      logic        neg;
      logic [63:0] sum;
      logic [127:0] wide;
      logic [63:0] rem;
      r = '0;
      neg = a[63] ^ b[63];
      r.lt = $signed(a) < $signed(b);
      r.eq = a == b;
      case (code)
         OP_ADD: begin
            sum = a + b;
            if (a[63] == b[63] && sum[63] != a[63]) begin
               r.ovf = 1'b1;
               r.value = a[63] ? NegMin : PosMax;
            end else begin
               r.value = sum;
            end
         end
         OP_MUL: begin
            wide = ({64'd0, abs64(a)} * {64'd0, abs64(b)}) / {64'd0, ScaleFactor};
            r.value = saturate(neg, wide, r.ovf);
         end
         OP_DIV: begin
            if (b == 64'd0) begin
               r.dz = 1'b1;
            end else begin
               wide = {64'd0, abs64(a) / abs64(b)} * {64'd0, ScaleFactor};
               r.value = saturate(neg, wide, r.ovf);
            end
         end
         OP_MOD: begin
            rem = abs64(a) % ScaleFactor;
            if (a[63] && rem != 64'd0) rem = ScaleFactor - rem;
            r.value = rem;
         end
         OP_CLAMP: begin
            if ($signed(c) < $signed(a)) r.value = c;
            else if ($signed(a) < $signed(b)) r.value = b;
            else r.value = a;
         end
         default: r.value = 64'd0;
      endcase
      return r;
   endfunction

   // sender: one beat, with random gap before it
   task automatic send_op(logic [2:0] code, logic [63:0] a, logic [63:0] b,
                          logic [63:0] c);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= code;
      req_tdata <= {c, b, a};
      pending_results.push_back(compute_alu(code, a, b, c));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      logic [63:0] v;
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: v = {{32{1'b0}}, $urandom} % 64'd100000000000;
         2: v = 64'd0 - ({{32{1'b0}}, $urandom} % 64'd100000000000);
         3: v = {$urandom_range(0, 40), 6'd0} * ScaleFactor / 64'd64;
         4: v = $urandom_range(0, 1) ? PosMax - $urandom_range(0, 3)
                                     : NegMin + $urandom_range(0, 3);
         default: v = $signed({{32{1'b0}}, $urandom} % 64'd20000000) - 64'sd10000000;
      endcase
      return v;
   endfunction

   task automatic test_directed();
      send_op(OP_ADD, PosMax, 64'd1, 64'd0);
      send_op(OP_ADD, NegMin, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      send_op(OP_ADD, PosMax, NegMin, 64'd0);
      send_op(OP_MUL, PosMax, PosMax, 64'd0);
      send_op(OP_MUL, NegMin, 64'd1000000, 64'd0);
      send_op(OP_MUL, NegMin, 64'd2000000, 64'd0);
      send_op(OP_MUL, 64'hFFFF_FFFF_FFF0_BDC0, 64'd2500000, 64'd0);
      send_op(OP_DIV, 64'd5000000, 64'd0, 64'd0);
      send_op(OP_DIV, NegMin, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      send_op(OP_DIV, PosMax, 64'd1, 64'd0);
      send_op(OP_DIV, 64'hFFFF_FFFF_FFB3_B4C0, 64'd2000000, 64'd0);
      send_op(OP_MOD, 64'd0, 64'd0, 64'd0);
      send_op(OP_MOD, 64'd3000000, 64'd0, 64'd0);
      send_op(OP_MOD, 64'hFFFF_FFFF_FFF8_5EE0, 64'd0, 64'd0);
      send_op(OP_MOD, NegMin, PosMax, 64'd0);
      send_op(OP_CLAMP, 64'd50, 64'd10, 64'd20);
      send_op(OP_CLAMP, 64'd5, 64'd10, 64'd20);
      send_op(OP_CLAMP, 64'd15, 64'd30, 64'd10);
      send_op(OP_CLAMP, NegMin, PosMax, NegMin);
      send_op(OP_CMP, 64'd7, 64'd7, PosMax);
      send_op(OP_CMP, NegMin, PosMax, 64'd0);
      send_op(CodeSpareLo, 64'd1, 64'd2, 64'd3);
      send_op(CodeSpareHi, PosMax, PosMax, NegMin);
   endtask

   task automatic test_random(int count);
      logic [2:0] code;
      logic [63:0] a;
      logic [63:0] b;
      for (int i = 0; i < count; i++) begin
         code = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
         a = rand64();
         b = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? a : 64'd0) : rand64();
         send_op(code, a, b, rand64());
      end
   endtask

   // long result hold-off while the sender keeps going
   task automatic test_backpressure();
      hold_off_cycles = 300;
      test_random(150);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (stall_enable) begin
         rsp_tready <= (cycle_count % 64) < 40 ? ($urandom_range(0, 3) != 0) : 1'b1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      alu_result_type got;
      alu_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[67:0];
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result beat %h", got);
         end else begin
            want = pending_results.pop_front();
            if (got.value !== want.value || got.lt !== want.lt || got.eq !== want.eq
                  || got.dz !== want.dz || got.ovf !== want.ovf) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected %h %b%b%b%b got %h %b%b%b%b",
                     want.value, want.lt, want.eq, want.dz, want.ovf,
                     got.value, got.lt, got.eq, got.dz, got.ovf);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("decimal_fixed_point_alu_top verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      hold_off_cycles = 0;
      stall_enable = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      stall_enable = 1'b1;
      test_random(500);
      test_backpressure();
      stall_enable = 1'b0;
      test_random(200);
      stall_enable = 1'b1;
      test_random(200);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("decimal_fixed_point_alu_top verification clean");
      end else begin
         $display("decimal_fixed_point_alu_top verification failed");
      end
      $finish;
   end

endmodule
